FILE: design/psch_pkg.sv
// ---------------------------------------------------------------------------
// psch_pkg: shared types for the preemptive priority scheduler
// Transfer payload structs, controller state encoding and the
// command/status groups between controller and datapath.
// ---------------------------------------------------------------------------
package psch_pkg;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // input transfer payload
  typedef struct packed {
    logic        action;
    logic [7:0]  proc_id;
    logic [15:0] arrive_at;
    logic [15:0] run_length;
    logic [7:0]  prio_level;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic [15:0] tick_time;
    logic        busy_res;
    logic [7:0]  running_id;
    logic        first_dispatch;
    logic        completed_now;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [23:0] sum_waiting;
    logic [23:0] sum_turnaround;
    logic        all_done;
  } out_t;

  // saturation limit of the running totals
  localparam logic [23:0] SUM_MAX = 24'hFFFFFF;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } st_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // write the input process into the next free slot
    logic scan_clr;  // start a new tick: clear scan pointer and best pick
    logic scan_rd;   // read the slot at the scan pointer, advance pointer
    logic commit;    // apply the pick, advance time, post the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;  // scan pointer has passed the last loaded slot
  } stat_t;

endpackage

FILE: design/psch_ctrl.sv
// ---------------------------------------------------------------------------
// psch_ctrl: scheduler sequencer
// Accepts commands, walks the slot scan and triggers the commit of a tick.
// ---------------------------------------------------------------------------
module psch_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  psch_pkg::stat_t   stat_i,
  output logic              busy,
  output psch_pkg::cmd_t    cmd_o
);

  psch_pkg::st_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psch_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    busy      = 1'b1;
    case (state_r)
      psch_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_action == psch_pkg::ACT_TICK) begin
            cmd_o.scan_clr = 1'b1;
            state_nxt      = psch_pkg::ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      psch_pkg::ST_SCAN: begin
        if (stat_i.scan_end) begin
          state_nxt = psch_pkg::ST_COMMIT;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      psch_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_nxt    = psch_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = psch_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/psch_dp.sv
// ---------------------------------------------------------------------------
// psch_dp: scheduler datapath
// Process table memories, done flags, best-pick compare, time and totals,
// and the registered result.
// ---------------------------------------------------------------------------
module psch_dp #(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psch_pkg::cmd_t    cmd_i,
  input  psch_pkg::in_t     in_data,
  output psch_pkg::stat_t   stat_o,
  output logic              out_strobe,
  output psch_pkg::out_t    out_data
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS);

  // static part of a table slot
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
  } slot_t;

  slot_t         ent_mem [MAX_PROCS];
  logic [15:0]   rem_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] done_r;

  logic [CW-1:0] loaded_cnt_r;
  logic [CW-1:0] fin_cnt_r;
  logic [CW-1:0] fin_cnt_nxt;
  logic [15:0]   now_r;
  logic [23:0]   wait_tot_r;
  logic [23:0]   turn_tot_r;
  logic [23:0]   wait_tot_nxt;
  logic [23:0]   turn_tot_nxt;

  logic [CW-1:0] scan_idx_r;
  logic          pend_r;
  logic [IW-1:0] rd_idx_r;
  slot_t         rd_ent_r;
  logic [15:0]   rd_rem_r;
  logic          rd_done_r;

  logic          best_found_r;
  logic [IW-1:0] best_idx_r;
  slot_t         best_ent_r;
  logic [15:0]   best_rem_r;

  logic          load_ok;
  logic          cand_ok;
  logic          take;
  logic          fin_now;
  logic [15:0]   fin_t;
  logic [15:0]   tat_t;
  logic [15:0]   wt_t;
  logic [24:0]   wsum;
  logic [24:0]   tsum;

  psch_pkg::out_t out_data_r;
  logic           out_strobe_r;

  assign load_ok = cmd_i.load && (loaded_cnt_r != CNT_MAX);
  assign stat_o.scan_end = (scan_idx_r == loaded_cnt_r);

  // table writes: load fills the next slot, commit decrements the pick
  always_ff @(posedge clk) begin
    if (load_ok) begin
      ent_mem[loaded_cnt_r[IW-1:0]] <= '{id: in_data.proc_id, arr: in_data.arrive_at,
                                         burst: in_data.run_length,
                                         prio: in_data.prio_level};
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      rem_mem[loaded_cnt_r[IW-1:0]] <= in_data.run_length;
    end else if (cmd_i.commit && best_found_r) begin
      rem_mem[best_idx_r] <= 16'(best_rem_r - 16'd1);
    end
  end

  // registered scan read
  always_ff @(posedge clk) begin
    if (cmd_i.scan_rd) begin
      rd_idx_r  <= scan_idx_r[IW-1:0];
      rd_ent_r  <= ent_mem[scan_idx_r[IW-1:0]];
      rd_rem_r  <= rem_mem[scan_idx_r[IW-1:0]];
      rd_done_r <= done_r[scan_idx_r[IW-1:0]];
    end
  end

  // scan pointer and read-pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      pend_r <= cmd_i.scan_rd;
      if (cmd_i.scan_clr) begin
        scan_idx_r <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_idx_r <= CW'(scan_idx_r + 1'b1);
      end
    end
  end

  // candidate test: ready slot beating the current pick
  assign cand_ok = !rd_done_r && (rd_rem_r != 16'd0) && (rd_ent_r.arr <= now_r);
  assign take = pend_r && cand_ok &&
                (!best_found_r || (rd_ent_r.prio < best_ent_r.prio) ||
                 ((rd_ent_r.prio == best_ent_r.prio) && (rd_ent_r.arr < best_ent_r.arr)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      best_found_r <= 1'b0;
    end else if (take) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= rd_idx_r;
      best_ent_r <= rd_ent_r;
      best_rem_r <= rd_rem_r;
    end
  end

  // completion figures of the pick
  assign fin_now = best_found_r && (best_rem_r == 16'd1);
  assign fin_t   = 16'(now_r + 16'd1);
  assign tat_t   = 16'(fin_t - best_ent_r.arr);
  assign wt_t    = 16'(tat_t - best_ent_r.burst);
  assign wsum    = {1'b0, wait_tot_r} + {9'd0, wt_t};
  assign tsum    = {1'b0, turn_tot_r} + {9'd0, tat_t};

  always_comb begin
    wait_tot_nxt = wait_tot_r;
    turn_tot_nxt = turn_tot_r;
    fin_cnt_nxt  = fin_cnt_r;
    if (cmd_i.commit && fin_now) begin
      wait_tot_nxt = (wsum > {1'b0, psch_pkg::SUM_MAX}) ? psch_pkg::SUM_MAX : wsum[23:0];
      turn_tot_nxt = (tsum > {1'b0, psch_pkg::SUM_MAX}) ? psch_pkg::SUM_MAX : tsum[23:0];
      fin_cnt_nxt  = CW'(fin_cnt_r + 1'b1);
    end else if (load_ok && (in_data.run_length == 16'd0)) begin
      fin_cnt_nxt  = CW'(fin_cnt_r + 1'b1);
    end
  end

  // counters, time, totals and done flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_cnt_r <= '0;
      fin_cnt_r    <= '0;
      now_r        <= '0;
      wait_tot_r   <= '0;
      turn_tot_r   <= '0;
      done_r       <= '0;
    end else begin
      fin_cnt_r  <= fin_cnt_nxt;
      wait_tot_r <= wait_tot_nxt;
      turn_tot_r <= turn_tot_nxt;
      if (load_ok) begin
        loaded_cnt_r <= CW'(loaded_cnt_r + 1'b1);
        done_r[loaded_cnt_r[IW-1:0]] <= (in_data.run_length == 16'd0);
      end
      if (cmd_i.commit) begin
        now_r <= fin_t;
        if (fin_now) begin
          done_r[best_idx_r] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_data_r.tick_time      <= now_r;
      out_data_r.busy_res       <= best_found_r;
      out_data_r.running_id     <= best_found_r ? best_ent_r.id : 8'd0;
      out_data_r.first_dispatch <= best_found_r && (best_rem_r == best_ent_r.burst);
      out_data_r.completed_now  <= fin_now;
      out_data_r.finish_time    <= fin_now ? fin_t : 16'd0;
      out_data_r.turnaround     <= fin_now ? tat_t : 16'd0;
      out_data_r.waiting        <= fin_now ? wt_t : 16'd0;
      out_data_r.sum_waiting    <= wait_tot_nxt;
      out_data_r.sum_turnaround <= turn_tot_nxt;
      out_data_r.all_done       <= (fin_cnt_nxt == loaded_cnt_r);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // every commit posts exactly one result on the next cycle
  a_commit_posts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |=> out_strobe_r)
    else $error("commit did not post a result");

  // a completion is only reported for a process that ran
  a_done_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.completed_now) |-> out_data_r.busy_res)
    else $error("completion reported on idle tick");

  // the table never holds more than its size, nor more finished than loaded
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (loaded_cnt_r <= CNT_MAX) && (fin_cnt_r <= loaded_cnt_r))
    else $error("slot counters out of range");

  // the scan never reads past the loaded slots
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.scan_rd |-> (scan_idx_r < loaded_cnt_r))
    else $error("scan read beyond loaded slots");

endmodule

FILE: design/preemptive_priority_scheduler.sv
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler: table-based priority scheduler
// Loads processes into a slot table and, per tick, runs the ready process
// with the smallest priority number, reporting completion statistics.
// ---------------------------------------------------------------------------
//  channel | ports                    | transfer
//  --------+--------------------------+---------------------------------------
//  input   | start, busy, in_data     | edge with start high and busy low
//  result  | out_strobe, out_data     | one cycle strobe, cannot be stalled
//
//  A load transfer completes in its accept cycle; busy stays low.
//  A tick scans the slot table: the slot scan reads one table entry
//  per cycle from the slot memories, then the pick is committed, and the result
//  strobes in the cycle after commit (busy is already low then).
//  rst_n is synchronous; reset empties the table, time and totals.
//  The result side has no back pressure; out_data is valid only with out_strobe.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  psch_pkg::in_t    in_data,
  output logic             out_strobe,
  output psch_pkg::out_t   out_data
);

  psch_pkg::cmd_t  cmd;
  psch_pkg::stat_t stat;

  // sequencer
  psch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_data.action),
    .stat_i    (stat),
    .busy      (busy),
    .cmd_o     (cmd)
  );

  // tables and arithmetic
  psch_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .in_data    (in_data),
    .stat_o     (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
